// ----- design/dcrtq_pkg.sv -----
// ----------------------------------------------------------------------------
// dcrtq_pkg
// Shared types and constants for the duty-cycled radio transmit queue.
// ----------------------------------------------------------------------------
package dcrtq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_SEND   = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_BEACON = 2'd3;

    // MAC answers
    localparam logic [1:0] ANS_ACCEPT = 2'd0;
    localparam logic [1:0] ANS_BUSY   = 2'd1;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_QUEUED    = 2'd1;
    localparam logic [1:0] ST_REFUSED   = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_FRAME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_CYCLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ON_SLOTS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_MISS_LIMIT = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_SLOTS_PER_FRAME   = 16'd16;
    localparam logic [15:0] RST_FRAMES_PER_CYCLE  = 16'd10;
    localparam logic [15:0] RST_ACTIVE_ON_SLOTS   = 16'd8;
    localparam logic [15:0] RST_BEACON_MISS_LIMIT = 16'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] packet_ref;
        logic [7:0]  packet_length;
        logic [15:0] dest_addr;
        logic [1:0]  mac_answer;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        offer_valid;
        logic [15:0] offer_ref;
        logic [7:0]  offer_length;
        logic [15:0] offer_dest;
        logic        radio_enabled;
        logic        radio_restart;
        logic        active_mode;
    } result_t;

    typedef struct packed {
        logic [15:0] packet_ref;
        logic [7:0]  packet_length;
        logic [15:0] dest_addr;
    } desc_t;

endpackage

// ----- design/duty_cycled_radio_tx_queue_top.sv -----
// ----------------------------------------------------------------------------
// duty_cycled_radio_tx_queue_top
// A result strobes on result_valid after start is taken, once the item has passed the input and result registers.
// Throughput: one item per cycle; busy stays low, set by one register stage
// for the item and one for the result around the slot/queue update logic.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset: rst_n clears counters, mode, radio (on), queue pointers (empty) and
// the registers to their defaults; queue entries are not cleared.
// ----------------------------------------------------------------------------
module duty_cycled_radio_tx_queue_top
    import dcrtq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    output logic                  result_valid,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

    // configuration
    logic        queue_enable_reg;
    logic [15:0] slots_per_frame_reg;
    logic [15:0] frames_per_cycle_reg;
    logic [15:0] active_on_slots_reg;
    logic [15:0] beacon_miss_limit_reg;

    // input stage
    logic        in_valid_reg;
    item_t       in_reg;

    // state
    logic        mode_reg, mode_next;
    logic [15:0] slot_reg, slot_next;
    logic [15:0] frame_reg, frame_next;
    logic [15:0] miss_reg, miss_next;
    logic        radio_reg, radio_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic        empty_reg, empty_next;
    desc_t       queue_mem_reg [QUEUE_DEPTH];
    logic        queue_we;
    desc_t       head_desc;
    desc_t       new_desc;

    // result stage
    logic        result_valid_reg;
    result_t     result_reg, result_next;

    logic        cfg_we;
    logic        queue_full;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    assign head_desc  = queue_mem_reg[head_reg];
    assign queue_full = !empty_reg && (head_reg == tail_reg);
    assign head_inc   = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc   = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign new_desc   = '{packet_ref: in_reg.packet_ref,
                          packet_length: in_reg.packet_length,
                          dest_addr: in_reg.dest_addr};

    always_comb
    begin
        mode_next   = mode_reg;
        slot_next   = slot_reg;
        frame_next  = frame_reg;
        miss_next   = miss_reg;
        radio_next  = radio_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        queue_we    = 1'b0;
        result_next = '0;

        if (in_valid_reg) begin
            case (in_reg.kind)
                KIND_TICK:
                begin
                    slot_next = slot_reg + 16'd1;
                    if (slot_next >= slots_per_frame_reg) begin
                        slot_next = '0;
                        if (mode_reg) begin
                            miss_next = miss_reg + 16'd1;
                            if (miss_next >= beacon_miss_limit_reg) begin
                                mode_next = 1'b0;
                            end
                        end else begin
                            frame_next = frame_reg + 16'd1;
                            if (frame_next >= frames_per_cycle_reg) begin
                                frame_next = '0;
                            end
                        end
                    end
                    // frame start: switch on (and flush) or switch off
                    if (slot_next == '0) begin
                        if (mode_next || frame_next == '0) begin
                            empty_next = 1'b1;
                            radio_next = 1'b1;
                            result_next.radio_restart = 1'b1;
                        end else if (frame_next == 16'd1) begin
                            radio_next = 1'b0;
                        end
                    end
                    if (mode_next && slot_next == active_on_slots_reg) begin
                        radio_next = 1'b0;
                    end
                end
                KIND_SEND:
                begin
                    if (!radio_reg) begin
                        result_next.status = ST_REFUSED;
                    end else begin
                        result_next.offer_valid  = 1'b1;
                        result_next.offer_ref    = in_reg.packet_ref;
                        result_next.offer_length = in_reg.packet_length;
                        result_next.offer_dest   = in_reg.dest_addr;
                        if (in_reg.mac_answer == ANS_ACCEPT) begin
                            result_next.status = ST_OK;
                        end else if (in_reg.mac_answer != ANS_BUSY) begin
                            result_next.status = ST_TOO_LARGE;
                        end else if (!queue_enable_reg || queue_full) begin
                            result_next.status = ST_REFUSED;
                        end else begin
                            queue_we = 1'b1;
                            if (empty_reg) begin
                                head_next  = tail_reg;
                                empty_next = 1'b0;
                            end
                            tail_next = tail_inc;
                            result_next.status = ST_QUEUED;
                        end
                    end
                end
                KIND_DONE:
                begin
                    if (queue_enable_reg && !empty_reg && radio_reg) begin
                        result_next.offer_valid  = 1'b1;
                        result_next.offer_ref    = head_desc.packet_ref;
                        result_next.offer_length = head_desc.packet_length;
                        result_next.offer_dest   = head_desc.dest_addr;
                        if (in_reg.mac_answer == ANS_ACCEPT) begin
                            // pop the head
                            head_next  = head_inc;
                            empty_next = (head_inc == tail_reg);
                            result_next.status = ST_OK;
                        end else if (in_reg.mac_answer == ANS_BUSY) begin
                            result_next.status = ST_REFUSED;
                        end else begin
                            result_next.status = ST_TOO_LARGE;
                        end
                    end
                end
                default:
                begin
                    mode_next = 1'b1;
                    miss_next = '0;
                end
            endcase
        end

        // enabling the queue drops whatever it held
        if (cfg_we && cfg_index == CFG_QUEUE_ENABLE && cfg_data[0]) begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
        end

        result_next.radio_enabled = radio_next;
        result_next.active_mode   = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            queue_enable_reg      <= 1'b0;
            slots_per_frame_reg   <= RST_SLOTS_PER_FRAME;
            frames_per_cycle_reg  <= RST_FRAMES_PER_CYCLE;
            active_on_slots_reg   <= RST_ACTIVE_ON_SLOTS;
            beacon_miss_limit_reg <= RST_BEACON_MISS_LIMIT;
            in_valid_reg          <= 1'b0;
            mode_reg              <= 1'b0;
            slot_reg              <= '0;
            frame_reg             <= '0;
            miss_reg              <= '0;
            radio_reg             <= 1'b1;
            head_reg              <= '0;
            tail_reg              <= '0;
            empty_reg             <= 1'b1;
            result_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_QUEUE_ENABLE:      queue_enable_reg      <= cfg_data[0];
                    CFG_SLOTS_PER_FRAME:   slots_per_frame_reg   <= cfg_data;
                    CFG_FRAMES_PER_CYCLE:  frames_per_cycle_reg  <= cfg_data;
                    CFG_ACTIVE_ON_SLOTS:   active_on_slots_reg   <= cfg_data;
                    CFG_BEACON_MISS_LIMIT: beacon_miss_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            in_valid_reg     <= start && !busy;
            mode_reg         <= mode_next;
            slot_reg         <= slot_next;
            frame_reg        <= frame_next;
            miss_reg         <= miss_next;
            radio_reg        <= radio_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            empty_reg        <= empty_next;
            result_valid_reg <= in_valid_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (start && !busy) begin
            in_reg <= item;
        end
        if (in_valid_reg) begin
            result_reg <= result_next;
        end
        if (queue_we) begin
            queue_mem_reg[tail_reg] <= new_desc;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> result_valid_reg)
        else $error("accepted item produced no result");

    a_idle_offer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.offer_valid |->
            result_reg.offer_ref == '0 && result_reg.offer_length == '0 &&
            result_reg.offer_dest == '0)
        else $error("offer fields not cleared without an offer");

    a_restart_no_offer: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.radio_restart |->
            !result_reg.offer_valid && result_reg.status == ST_OK)
        else $error("radio restart on a non-tick item");

    a_queued_offered: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.status == ST_QUEUED |->
            result_reg.offer_valid)
        else $error("item queued without an offer");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        queue_we |-> !queue_full && queue_enable_reg && radio_reg)
        else $error("queue written while full, disabled or radio off");

endmodule

// ----- verif/dcrtq_tx_check.sv -----
// ----------------------------------------------------------------------------
// dcrtq_tx_check
// Watches the item, result and register channels of the duty-cycled radio
// transmit queue, predicts the result of every accepted item from its own
// copy of the slot, frame, mode and queue state, and compares it field by
// field with the result that comes out. Hands the failure count and the
// number of results still awaited to the testbench top.
// ----------------------------------------------------------------------------
module dcrtq_tx_check
    import dcrtq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  item_t                 item,
    input  logic                  result_valid,
    input  result_t               result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fails,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copies
    logic        q_en;
    logic [15:0] spf;
    logic [15:0] fpc;
    logic [15:0] aos;
    logic [15:0] bml;

    // controller state
    logic             mode_act;
    logic             radio_en;
    logic [15:0]      slot_cnt;
    logic [15:0]      frame_cnt;
    logic [15:0]      miss_cnt;
    desc_t            q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] q_head;
    logic [PTR_W-1:0] q_tail;
    logic             q_empty;

    result_t expected_results [$];

    function automatic result_t radio_queue_step(item_t it);
        result_t r;
        r = '0;
        case (it.kind)
            KIND_TICK:
            begin
                slot_cnt = slot_cnt + 16'd1;
                if (slot_cnt >= spf) begin
                    slot_cnt = '0;
                    if (mode_act) begin
                        miss_cnt = miss_cnt + 16'd1;
                        if (miss_cnt >= bml)
                            mode_act = 1'b0;
                    end
                    else begin
                        frame_cnt = frame_cnt + 16'd1;
                        if (frame_cnt >= fpc)
                            frame_cnt = '0;
                    end
                end
                if (slot_cnt == 16'd0) begin
                    // switch-on restarts the MAC and drops the queue
                    if (mode_act || frame_cnt == 16'd0) begin
                        q_empty = 1'b1;
                        radio_en = 1'b1;
                        r.radio_restart = 1'b1;
                    end
                    else if (frame_cnt == 16'd1) begin
                        radio_en = 1'b0;
                    end
                end
                if (mode_act && slot_cnt == aos)
                    radio_en = 1'b0;
            end
            KIND_SEND:
            begin
                if (!radio_en) begin
                    r.status = ST_REFUSED;
                end
                else begin
                    r.offer_valid  = 1'b1;
                    r.offer_ref    = it.packet_ref;
                    r.offer_length = it.packet_length;
                    r.offer_dest   = it.dest_addr;
                    if (it.mac_answer == ANS_ACCEPT) begin
                        r.status = ST_OK;
                    end
                    else if (it.mac_answer != ANS_BUSY) begin
                        r.status = ST_TOO_LARGE;
                    end
                    else if (!q_en || (!q_empty && q_head == q_tail)) begin
                        r.status = ST_REFUSED;
                    end
                    else begin
                        q_mem[q_tail] = '{it.packet_ref, it.packet_length, it.dest_addr};
                        if (q_empty) begin
                            q_head = q_tail;
                            q_empty = 1'b0;
                        end
                        q_tail = q_tail + 1'b1;
                        r.status = ST_QUEUED;
                    end
                end
            end
            KIND_DONE:
            begin
                if (q_en && !q_empty && radio_en) begin
                    r.offer_valid  = 1'b1;
                    r.offer_ref    = q_mem[q_head].packet_ref;
                    r.offer_length = q_mem[q_head].packet_length;
                    r.offer_dest   = q_mem[q_head].dest_addr;
                    // pop only on accept; a refused head stays put
                    if (it.mac_answer == ANS_ACCEPT) begin
                        q_head = q_head + 1'b1;
                        if (q_head == q_tail)
                            q_empty = 1'b1;
                        r.status = ST_OK;
                    end
                    else begin
                        r.status = (it.mac_answer == ANS_BUSY) ? ST_REFUSED : ST_TOO_LARGE;
                    end
                end
            end
            default:
            begin
                mode_act = 1'b1;
                miss_cnt = '0;
            end
        endcase
        r.radio_enabled = radio_en;
        r.active_mode = mode_act;
        return r;
    endfunction

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            q_en      = 1'b0;
            spf       = RST_SLOTS_PER_FRAME;
            fpc       = RST_FRAMES_PER_CYCLE;
            aos       = RST_ACTIVE_ON_SLOTS;
            bml       = RST_BEACON_MISS_LIMIT;
            mode_act  = 1'b0;
            radio_en  = 1'b1;
            slot_cnt  = '0;
            frame_cnt = '0;
            miss_cnt  = '0;
            q_head    = '0;
            q_tail    = '0;
            q_empty   = 1'b1;
            fails     = 0;
            expected_results.delete();
        end
        else begin
            if (result_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result with nothing expected, actual %p", $time, result);
                    fails++;
                end
                else begin
                    want = expected_results.pop_front();
                    compare_field("status", 16'(want.status), 16'(result.status));
                    compare_field("offer_valid", 16'(want.offer_valid),
                                  16'(result.offer_valid));
                    compare_field("offer_ref", want.offer_ref, result.offer_ref);
                    compare_field("offer_length", 16'(want.offer_length),
                                  16'(result.offer_length));
                    compare_field("offer_dest", want.offer_dest, result.offer_dest);
                    compare_field("radio_enabled", 16'(want.radio_enabled),
                                  16'(result.radio_enabled));
                    compare_field("radio_restart", 16'(want.radio_restart),
                                  16'(result.radio_restart));
                    compare_field("active_mode", 16'(want.active_mode),
                                  16'(result.active_mode));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_QUEUE_ENABLE:
                    begin
                        q_en = cfg_data[0];
                        if (q_en) begin
                            q_head = '0;
                            q_tail = '0;
                            q_empty = 1'b1;
                        end
                    end
                    CFG_SLOTS_PER_FRAME:   spf = cfg_data;
                    CFG_FRAMES_PER_CYCLE:  fpc = cfg_data;
                    CFG_ACTIVE_ON_SLOTS:   aos = cfg_data;
                    CFG_BEACON_MISS_LIMIT: bml = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_results.push_back(radio_queue_step(item));
        end
        pending = expected_results.size();
    end

endmodule

// ----- verif/duty_cycled_radio_tx_queue_top_tb.sv -----
// ----------------------------------------------------------------------------
// duty_cycled_radio_tx_queue_top_tb
// Drives the radio transmit queue through a directed run that fills, overflows
// and partly drains the queue, then through random traffic under several register
// settings, zero and full-scale values among them. Items go in bursts with
// random gaps; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module duty_cycled_radio_tx_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dcrtq_pkg::*;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam logic [1:0] ANS_TOO_LARGE = 2'd2;
    localparam logic [1:0] ANS_UNDEF     = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  result_valid;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fails;
    int                    pending;
    int                    cycles;

    duty_cycled_radio_tx_queue_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    dcrtq_tx_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fails        (fails),
        .pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic item_t make_item(logic [1:0] kind, logic [15:0] pref, logic [7:0] plen,
                                        logic [15:0] dest, logic [1:0] ans);
        item_t it;
        it.kind          = kind;
        it.packet_ref    = pref;
        it.packet_length = plen;
        it.dest_addr     = dest;
        it.mac_answer    = ans;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    k;
        int    a;
        it = make_item(KIND_BEACON, 16'($urandom), 8'($urandom), 16'($urandom), 2'($urandom));
        k = $urandom_range(0, 99);
        a = $urandom_range(0, 9);
        if (k < 20) begin
            it.kind = KIND_TICK;
        end
        else if (k < 58) begin
            // lean on busy so the queue fills up
            it.kind = KIND_SEND;
            it.mac_answer = (a < 3) ? ANS_ACCEPT : (a < 7) ? ANS_BUSY :
                            (a < 9) ? ANS_TOO_LARGE : ANS_UNDEF;
        end
        else if (k < 90) begin
            it.kind = KIND_DONE;
            it.mac_answer = (a < 6) ? ANS_ACCEPT : (a < 8) ? ANS_BUSY :
                            (a < 9) ? ANS_TOO_LARGE : ANS_UNDEF;
        end
        return it;
    endfunction

    // hold start until the block takes the item
    task automatic drive_item(item_t it);
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic drain();
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic configure(logic qen, logic [15:0] spf, logic [15:0] fpc,
                             logic [15:0] aos, logic [15:0] bml);
        drain();
        // upper data bits of the enable register are don't-care
        write_reg(CFG_QUEUE_ENABLE, (16'($urandom) & 16'hFFFE) | 16'(qen));
        write_reg(CFG_SLOTS_PER_FRAME, spf);
        write_reg(CFG_FRAMES_PER_CYCLE, fpc);
        write_reg(CFG_ACTIVE_ON_SLOTS, aos);
        write_reg(CFG_BEACON_MISS_LIMIT, bml);
        write_reg(CFG_BEACON_MISS_LIMIT + 3'd1 + 3'($urandom_range(0, 2)), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic traffic(int n);
        int left;
        int burst;
        int gap;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst) begin
                drive_item(random_item());
                left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;
    endtask

    initial begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill, overflow, refuse and partly drain the queue
        configure(1'b1, 16'd16, 16'd10, 16'd8, 16'd5);
        drive_item(make_item(KIND_SEND, 16'hFFFF, 8'hFF, 16'hFFFF, ANS_ACCEPT));
        drive_item(make_item(KIND_SEND, 16'h0000, 8'h00, 16'h0000, ANS_BUSY));
        repeat (7)
            drive_item(make_item(KIND_SEND, 16'($urandom), 8'($urandom), 16'($urandom), ANS_BUSY));
        drive_item(make_item(KIND_SEND, 16'h1234, 8'h56, 16'h789A, ANS_BUSY));
        drive_item(make_item(KIND_SEND, 16'h0F0F, 8'hF0, 16'hF0F0, ANS_TOO_LARGE));
        drive_item(make_item(KIND_SEND, 16'hA5A5, 8'h5A, 16'h5A5A, ANS_UNDEF));
        drive_item(make_item(KIND_DONE, 16'h0000, 8'h00, 16'h0000, ANS_BUSY));
        drive_item(make_item(KIND_DONE, 16'h0000, 8'h00, 16'h0000, ANS_TOO_LARGE));
        drive_item(make_item(KIND_DONE, 16'h0000, 8'h00, 16'h0000, ANS_UNDEF));
        drive_item(make_item(KIND_DONE, 16'h0000, 8'h00, 16'h0000, ANS_ACCEPT));
        drive_item(make_item(KIND_DONE, 16'hFFFF, 8'hFF, 16'hFFFF, ANS_ACCEPT));
        drive_item(make_item(KIND_SEND, 16'h4321, 8'h10, 16'h0001, ANS_BUSY));
        drive_item(make_item(KIND_BEACON, 16'h0000, 8'h00, 16'h0000, ANS_ACCEPT));
        drive_item(make_item(KIND_TICK, 16'hFFFF, 8'hFF, 16'hFFFF, ANS_UNDEF));
        drive_item(make_item(KIND_TICK, 16'h0000, 8'h00, 16'h0000, ANS_ACCEPT));
        start <= 1'b0;

        configure(1'b1, 16'd3, 16'd2, 16'd1, 16'd2);
        traffic(80);
        configure(1'b1, 16'd1, 16'd3, 16'd0, 16'd1);
        traffic(80);
        configure(1'b0, 16'd4, 16'd2, 16'd2, 16'd3);
        traffic(70);
        configure(1'b1, 16'd0, 16'd0, 16'd0, 16'd1);
        traffic(70);
        configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        traffic(70);
        configure(1'b1, 16'd2, 16'd2, 16'hFFFF, 16'hFFFF);
        traffic(80);
        configure(1'b1, 16'd5, 16'd3, 16'd3, 16'd2);
        traffic(100);

        drain();
        repeat (4) @(posedge clk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
